// ===== rtl/resistive_touch_sample_filter_macros.svh =====
// assertion macros used by the touch filter port checker
`ifndef RESISTIVE_TOUCH_SAMPLE_FILTER_MACROS_SVH
`define RESISTIVE_TOUCH_SAMPLE_FILTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RTSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RTSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtsf_pkg.sv =====
// types and constants of the resistive touch sample filter
package rtsf_pkg;

  localparam int unsigned VAL_W      = 12;
  localparam int unsigned SUM_W      = 15;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SCALE_W    = 20;
  localparam int unsigned SCR_W      = 35;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [VAL_W-1:0]   VAL_ALL_ONES   = '1;
  localparam logic [POS_W-1:0]   POS_IDLE       = 16'hffff;
  localparam logic [SCALE_W-1:0] SCALE_RESET    = 20'h10000;
  localparam logic [VAL_W-1:0]   CENTER_RESET   = 12'd2048;
  localparam logic [VAL_W-1:0]   WINDOW_RESET   = 12'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_MODE        = 3'd0,
    CFG_X_SCALE         = 3'd1,
    CFG_Y_SCALE         = 3'd2,
    CFG_X_CENTER_RAW    = 3'd3,
    CFG_Y_CENTER_RAW    = 3'd4,
    CFG_X_CENTER_SCREEN = 3'd5,
    CFG_Y_CENTER_SCREEN = 3'd6,
    CFG_AGREE_WINDOW    = 3'd7
  } cfg_reg_e;

  typedef enum logic [IN_USER_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_PEN_UP = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  // what travels down the pipeline with each token
  typedef enum logic [1:0] {
    KIND_GROUP = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

endpackage

// ===== rtl/resistive_touch_sample_filter.sv =====
// resistive touch sample filter: trimmed group means, xy agreement, screen mapping
//
// input stream: s_axis_tuser carries the function code (pen-down sample, pen-up
// tick, clear capture), s_axis_tdata the 16-bit converter word. a pen-down
// sample produces a result only when it completes a scan of four groups of
// SAMPLES_PER_AXIS words (x, y, x, y); a tick or a clear always produces one.
// unused function codes are dropped without effect.
// output stream: m_axis_tuser holds pressed, captured, read_ok; m_axis_tdata
// holds x_pos, y_pos, first_x, first_y.
// one item is accepted per clock while s_axis_tready is high; a result shows on
// m_axis after passing the seven-register pipeline (input accumulate, trim,
// reciprocal multiply, mean gather, agreement, scale multiply, clamp).
// a stalled receiver holds the output register and every full stage behind it;
// empty pipeline stages keep s_axis_tready high until the stages back up to the input.
// reset clears the pipeline, the group accumulator and the press state, and
// loads the register defaults. config writes go on the cfg port, one per clock;
// the user must write only while the block is idle; the block does not enforce it.
module resistive_touch_sample_filter #(
  parameter int unsigned SAMPLES_PER_AXIS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rtsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rtsf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rtsf_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // sample_word
  input  logic [rtsf_pkg::IN_USER_W-1:0]    s_axis_tuser,   // func
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rtsf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // x_pos, y_pos, first_x, first_y
  output logic [rtsf_pkg::OUT_USER_W-1:0]   m_axis_tuser    // pressed, captured, read_ok
);
  import rtsf_pkg::*;

  localparam int unsigned IDX_W    = $clog2(SAMPLES_PER_AXIS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_AXIS - 1);
  localparam int unsigned DIV      = SAMPLES_PER_AXIS - 2;
  localparam int unsigned RECIP_SH = SUM_W + $clog2(DIV);
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned RECIP_I  = ((1 << RECIP_SH) + DIV - 1) / DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam int unsigned PRODS_W  = VAL_W + SCALE_W + 2;

  // configuration
  logic                raw_mode_q;
  logic [SCALE_W-1:0]  x_scale_q, y_scale_q;
  logic [VAL_W-1:0]    x_center_raw_q, y_center_raw_q;
  logic [POS_W-1:0]    x_center_screen_q, y_center_screen_q;
  logic [VAL_W-1:0]    agree_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q        <= 1'b0;
      x_scale_q         <= SCALE_RESET;
      y_scale_q         <= SCALE_RESET;
      x_center_raw_q    <= CENTER_RESET;
      y_center_raw_q    <= CENTER_RESET;
      x_center_screen_q <= '0;
      y_center_screen_q <= '0;
      agree_window_q    <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RAW_MODE:        raw_mode_q        <= cfg_data_i[0];
        CFG_X_SCALE:         x_scale_q         <= cfg_data_i[SCALE_W-1:0];
        CFG_Y_SCALE:         y_scale_q         <= cfg_data_i[SCALE_W-1:0];
        CFG_X_CENTER_RAW:    x_center_raw_q    <= cfg_data_i[VAL_W-1:0];
        CFG_Y_CENTER_RAW:    y_center_raw_q    <= cfg_data_i[VAL_W-1:0];
        CFG_X_CENTER_SCREEN: x_center_screen_q <= cfg_data_i[POS_W-1:0];
        CFG_Y_CENTER_SCREEN: y_center_screen_q <= cfg_data_i[POS_W-1:0];
        CFG_AGREE_WINDOW:    agree_window_q    <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !out_v_q || m_axis_tready;
  assign rdy6 = !p6_v_q || rdy7;
  assign rdy5 = !p5_v_q || rdy6;
  assign rdy4 = !p4_v_q || rdy5;
  assign rdy3 = !p3_v_q || rdy4;
  assign rdy2 = !p2_v_q || rdy3;
  assign rdy1 = !p1_v_q || rdy2;
  assign s_axis_tready = rdy1;

  // group accumulator, updated as items are accepted
  logic             accept;
  logic [VAL_W-1:0] sample_val;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       grp_q, grp_d;
  logic [SUM_W-1:0] sum_q, sum_d, sum_nx;
  logic [VAL_W-1:0] min_q, min_d, min_nx;
  logic [VAL_W-1:0] max_q, max_d, max_nx;
  logic             p1_in_v;
  kind_e            p1_in_kind;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign sample_val = ~s_axis_tdata[IN_DATA_W-1 -: VAL_W];
  assign sum_nx     = sum_q + SUM_W'(sample_val);
  assign min_nx     = (sample_val < min_q) ? sample_val : min_q;
  assign max_nx     = (sample_val > max_q) ? sample_val : max_q;

  always_comb begin
    idx_d      = idx_q;
    grp_d      = grp_q;
    sum_d      = sum_q;
    min_d      = min_q;
    max_d      = max_q;
    p1_in_v    = 1'b0;
    p1_in_kind = KIND_CLEAR;
    if (accept) begin
      case (func_e'(s_axis_tuser))
        FUNC_SAMPLE: begin
          if (idx_q == IDX_LAST) begin
            idx_d      = '0;
            grp_d      = grp_q + 2'd1;
            sum_d      = '0;
            min_d      = VAL_ALL_ONES;
            max_d      = '0;
            p1_in_v    = 1'b1;
            p1_in_kind = (grp_q == 2'd3) ? KIND_SCAN : KIND_GROUP;
          end else begin
            idx_d = idx_q + IDX_W'(1);
            sum_d = sum_nx;
            min_d = min_nx;
            max_d = max_nx;
          end
        end
        FUNC_PEN_UP: begin
          idx_d      = '0;
          grp_d      = '0;
          sum_d      = '0;
          min_d      = VAL_ALL_ONES;
          max_d      = '0;
          p1_in_v    = 1'b1;
          p1_in_kind = KIND_TICK;
        end
        FUNC_CLEAR: begin
          p1_in_v    = 1'b1;
          p1_in_kind = KIND_CLEAR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      grp_q <= '0;
      sum_q <= '0;
      min_q <= VAL_ALL_ONES;
      max_q <= '0;
    end else begin
      idx_q <= idx_d;
      grp_q <= grp_d;
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // stage 1: final sum, min and max of a finished group
  kind_e            p1_kind_q;
  logic [1:0]       p1_grp_q;
  logic [SUM_W-1:0] p1_sum_q;
  logic [VAL_W-1:0] p1_min_q, p1_max_q;

  // stage 2: trimmed sum
  kind_e            p2_kind_q;
  logic [1:0]       p2_grp_q;
  logic [SUM_W-1:0] p2_trim_q;

  // stage 3: trimmed sum times reciprocal of the divisor
  kind_e             p3_kind_q;
  logic [1:0]        p3_grp_q;
  logic [PROD_W-1:0] p3_prod_q;
  logic [VAL_W-1:0]  mean;

  // stored means of the first three groups of a scan
  logic [VAL_W-1:0]  axis_means_q [3];

  // stage 4: the two x and the two y means
  kind_e            p4_kind_q;
  logic [VAL_W-1:0] p4_x0_q, p4_x1_q, p4_y0_q, p4_y1_q;

  // stage 5: agreement, averages and offsets from center
  kind_e                   p5_kind_q;
  logic                    p5_ok_q;
  logic [VAL_W-1:0]        p5_ax_q, p5_ay_q;
  logic signed [VAL_W:0]   p5_dx_q, p5_dy_q;
  logic [VAL_W-1:0]        dist_x, dist_y;
  logic [VAL_W:0]          pair_x, pair_y;
  logic [VAL_W-1:0]        avg_x, avg_y;

  // stage 6: scaled offsets
  kind_e                     p6_kind_q;
  logic                      p6_ok_q;
  logic [VAL_W-1:0]          p6_ax_q, p6_ay_q;
  logic signed [PRODS_W-1:0] p6_px_q, p6_py_q;

  assign mean   = p3_prod_q[RECIP_SH +: VAL_W];
  assign dist_x = (p4_x0_q >= p4_x1_q) ? (p4_x0_q - p4_x1_q) : (p4_x1_q - p4_x0_q);
  assign dist_y = (p4_y0_q >= p4_y1_q) ? (p4_y0_q - p4_y1_q) : (p4_y1_q - p4_y0_q);
  assign pair_x = {1'b0, p4_x0_q} + {1'b0, p4_x1_q};
  assign pair_y = {1'b0, p4_y0_q} + {1'b0, p4_y1_q};
  assign avg_x  = pair_x[VAL_W:1];
  assign avg_y  = pair_y[VAL_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
    end else begin
      if (rdy1) p1_v_q <= p1_in_v;
      if (rdy2) p2_v_q <= p1_v_q;
      if (rdy3) p3_v_q <= p2_v_q;
      if (rdy4) p4_v_q <= p3_v_q && (p3_kind_q != KIND_GROUP);
      if (rdy5) p5_v_q <= p4_v_q;
      if (rdy6) p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p1_kind_q <= p1_in_kind;
      p1_grp_q  <= grp_q;
      p1_sum_q  <= sum_nx;
      p1_min_q  <= min_nx;
      p1_max_q  <= max_nx;
    end
    if (rdy2) begin
      p2_kind_q <= p1_kind_q;
      p2_grp_q  <= p1_grp_q;
      p2_trim_q <= p1_sum_q - SUM_W'(p1_min_q) - SUM_W'(p1_max_q);
    end
    if (rdy3) begin
      p3_kind_q <= p2_kind_q;
      p3_grp_q  <= p2_grp_q;
      p3_prod_q <= PROD_W'(p2_trim_q) * PROD_W'(RECIP);
    end
    if (rdy4) begin
      if (p3_v_q && p3_kind_q == KIND_GROUP) begin
        axis_means_q[p3_grp_q] <= mean;
      end
      p4_kind_q <= p3_kind_q;
      p4_x0_q   <= axis_means_q[0];
      p4_y0_q   <= axis_means_q[1];
      p4_x1_q   <= axis_means_q[2];
      p4_y1_q   <= mean;
    end
    if (rdy5) begin
      p5_kind_q <= p4_kind_q;
      p5_ok_q   <= (dist_x < agree_window_q) && (dist_y < agree_window_q);
      p5_ax_q   <= avg_x;
      p5_ay_q   <= avg_y;
      p5_dx_q   <= $signed({1'b0, avg_x}) - $signed({1'b0, x_center_raw_q});
      p5_dy_q   <= $signed({1'b0, avg_y}) - $signed({1'b0, y_center_raw_q});
    end
    if (rdy6) begin
      p6_kind_q <= p5_kind_q;
      p6_ok_q   <= p5_ok_q;
      p6_ax_q   <= p5_ax_q;
      p6_ay_q   <= p5_ay_q;
      p6_px_q   <= PRODS_W'(p5_dx_q) * PRODS_W'($signed({1'b0, x_scale_q}));
      p6_py_q   <= PRODS_W'(p5_dy_q) * PRODS_W'($signed({1'b0, y_scale_q}));
    end
  end

  // final stage: clamp to screen range and update press state
  function automatic logic [POS_W-1:0] clamp_screen(input logic signed [SCR_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v[SCR_W-1]) begin
      r = '0;
    end else if (|v[SCR_W-2:2*POS_W]) begin
      r = POS_IDLE;
    end else begin
      r = v[2*POS_W-1:POS_W];
    end
    return r;
  endfunction

  logic signed [SCR_W-1:0] vx, vy;
  logic [POS_W-1:0] scr_x, scr_y;
  logic [POS_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [POS_W-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic             down_q, down_d, capture_q, capture_d;
  logic             read_ok;
  logic             fire;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  assign vx    = SCR_W'(p6_px_q) + SCR_W'($signed({1'b0, x_center_screen_q, {POS_W{1'b0}}}));
  assign vy    = SCR_W'(p6_py_q) + SCR_W'($signed({1'b0, y_center_screen_q, {POS_W{1'b0}}}));
  assign scr_x = clamp_screen(vx);
  assign scr_y = clamp_screen(vy);
  assign fire  = p6_v_q && rdy7;

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    down_d    = down_q;
    capture_d = capture_q;
    read_ok   = 1'b0;
    if (fire) begin
      case (p6_kind_q)
        KIND_SCAN: begin
          if (p6_ok_q) begin
            read_ok = 1'b1;
            cur_x_d = raw_mode_q ? POS_W'(p6_ax_q) : scr_x;
            cur_y_d = raw_mode_q ? POS_W'(p6_ay_q) : scr_y;
          end
          // first completed scan of a press
          if (!down_q) begin
            down_d    = 1'b1;
            capture_d = 1'b1;
            start_x_d = cur_x_d;
            start_y_d = cur_y_d;
          end
        end
        KIND_TICK: begin
          if (down_q) begin
            down_d = 1'b0;
          end else begin
            start_x_d = '0;
            start_y_d = '0;
            cur_x_d   = POS_IDLE;
            cur_y_d   = POS_IDLE;
          end
        end
        KIND_CLEAR: begin
          capture_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= POS_IDLE;
      cur_y_q   <= POS_IDLE;
      start_x_q <= '0;
      start_y_q <= '0;
      down_q    <= 1'b0;
      capture_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      down_q    <= down_d;
      capture_q <= capture_d;
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {start_y_d, start_x_d, cur_y_d, cur_x_d};
      out_user_q <= {read_ok, capture_d, down_d};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/rtsf_port_checker.sv =====
// port-level checks of the touch filter, bound to the top level
`include "resistive_touch_sample_filter_macros.svh"

module rtsf_port_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rtsf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [rtsf_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import rtsf_pkg::*;

  logic res_pressed, res_read_ok;

  assign res_pressed = m_axis_tuser[0];
  assign res_read_ok = m_axis_tuser[2];

  // a stalled result keeps its contents
  `RTSF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // a scan that agreed always leaves the pen down
  `RTSF_ASSERT_SAME(a_ok_pressed, clk_i, rst_ni, m_axis_tvalid && res_read_ok, res_pressed, "read_ok without pressed")

  // with the output register empty the whole pipeline can move
  `RTSF_ASSERT_SAME(a_ready_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind resistive_touch_sample_filter rtsf_port_checker u_rtsf_port_checker (.*);

// ===== tb/tb.sv =====
// testbench for the resistive touch sample filter: streamed stimulus, scan predictor, result check
`timescale 1ns / 1ps

module tb;
  import rtsf_pkg::*;

  localparam int unsigned SAMPLES        = 5;
  localparam int unsigned SCAN_LEN       = 4 * SAMPLES;
  localparam logic [IN_USER_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 400;

  typedef struct {
    logic [IN_USER_W-1:0] func;
    logic [IN_DATA_W-1:0] word;
  } touch_item_t;

  typedef struct {
    logic        pressed;
    logic        captured;
    logic        read_ok;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] first_x;
    logic [15:0] first_y;
  } touch_report_t;

  typedef struct {
    logic        raw_mode;
    logic [19:0] x_scale;
    logic [19:0] y_scale;
    logic [11:0] x_center_raw;
    logic [11:0] y_center_raw;
    logic [15:0] x_center_screen;
    logic [15:0] y_center_screen;
    logic [11:0] agree_window;
  } touch_cfg_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // pending stimulus and predicted results
  touch_item_t   touch_items_q[$];
  touch_report_t touch_reports_q[$];

  // predictor copy of the filter state and registers
  touch_cfg_t  cfg_m;
  logic [4:0]  smp_idx;
  logic [14:0] grp_sum;
  logic [11:0] grp_min;
  logic [11:0] grp_max;
  logic [11:0] axis_mean [4];
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [15:0] first_x_m;
  logic [15:0] first_y_m;
  logic        pen_down;
  logic        capture_pend;

  int    err_count = 0;
  int    counted_items = 0;
  int    stall_cycles = 0;
  int    tx_burst = 0;
  int    tx_gap = 0;
  int    rx_run = 0;
  int    out_hold = 0;
  logic  rx_on = 1'b0;
  logic  item_taken = 1'b0;
  logic  result_taken;
  touch_report_t want_r;
  logic [15:0]   got_f [7];
  logic [15:0]   want_f [7];
  string         field_name [7] = '{"pressed", "captured", "read_ok", "x_pos", "y_pos",
                                    "first_x", "first_y"};

  resistive_touch_sample_filter #(
    .SAMPLES_PER_AXIS(SAMPLES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_group();
    grp_sum = '0;
    grp_min = 12'hfff;
    grp_max = '0;
  endfunction

  function automatic void reset_filter_model();
    cfg_m = '{1'b0, SCALE_RESET, SCALE_RESET, CENTER_RESET, CENTER_RESET, 16'h0, 16'h0,
              WINDOW_RESET};
    smp_idx = '0;
    clear_group();
    for (int i = 0; i < 4; i++) axis_mean[i] = '0;
    cur_x = POS_IDLE;
    cur_y = POS_IDLE;
    first_x_m = '0;
    first_y_m = '0;
    pen_down = 1'b0;
    capture_pend = 1'b0;
  endfunction

  function automatic logic readings_agree(logic [11:0] a, logic [11:0] b);
    logic [11:0] d;
    d = (a > b) ? a - b : b - a;
    return d < cfg_m.agree_window;
  endfunction

  function automatic logic [15:0] map_to_screen(logic [11:0] raw, logic [11:0] ctr,
                                                logic [19:0] scale, logic [15:0] scr);
    longint r;
    longint c;
    longint s;
    longint z;
    longint v;
    r = raw;
    c = ctr;
    s = scale;
    z = scr;
    v = (r - c) * s + z * 65536;
    if (v < 0) return 16'h0;
    v = v >>> 16;
    if (v > 65535) return 16'hffff;
    return v[15:0];
  endfunction

  function automatic void post_touch_report(logic ok);
    touch_reports_q.push_back(touch_report_t'{pen_down, capture_pend, ok, cur_x, cur_y,
                                              first_x_m, first_y_m});
  endfunction

  function automatic void apply_touch_item(touch_item_t it);
    logic [11:0] v;
    logic [14:0] trimmed;
    logic [12:0] sx;
    logic [12:0] sy;
    int unsigned pos;
    int unsigned grp;
    logic        ok;
    case (it.func)
      FUNC_SAMPLE: begin
        v = 12'hfff - it.word[15:4];
        grp_sum = grp_sum + 15'(v);
        if (v < grp_min) grp_min = v;
        if (v > grp_max) grp_max = v;
        pos = smp_idx % SAMPLES;
        grp = smp_idx / SAMPLES;
        smp_idx = smp_idx + 5'd1;
        if (pos == SAMPLES - 1) begin
          trimmed = grp_sum - 15'(grp_min) - 15'(grp_max);
          axis_mean[grp[1:0]] = 12'(trimmed / (SAMPLES - 2));
          clear_group();
          if (grp == 3) begin
            smp_idx = '0;
            ok = 1'b0;
            if (readings_agree(axis_mean[0], axis_mean[2]) &&
                readings_agree(axis_mean[1], axis_mean[3])) begin
              sx = 13'(axis_mean[0]) + 13'(axis_mean[2]);
              sy = 13'(axis_mean[1]) + 13'(axis_mean[3]);
              ok = 1'b1;
              if (cfg_m.raw_mode) begin
                cur_x = 16'(sx[12:1]);
                cur_y = 16'(sy[12:1]);
              end else begin
                cur_x = map_to_screen(sx[12:1], cfg_m.x_center_raw, cfg_m.x_scale,
                                      cfg_m.x_center_screen);
                cur_y = map_to_screen(sy[12:1], cfg_m.y_center_raw, cfg_m.y_scale,
                                      cfg_m.y_center_screen);
              end
            end
            // first completed scan of a press latches the start point
            if (!pen_down) begin
              pen_down = 1'b1;
              capture_pend = 1'b1;
              first_x_m = cur_x;
              first_y_m = cur_y;
            end
            post_touch_report(ok);
          end
        end
      end
      FUNC_PEN_UP: begin
        smp_idx = '0;
        clear_group();
        if (pen_down) begin
          pen_down = 1'b0;
        end else begin
          first_x_m = '0;
          first_y_m = '0;
          cur_x = POS_IDLE;
          cur_y = POS_IDLE;
        end
        post_touch_report(1'b0);
      end
      FUNC_CLEAR: begin
        capture_pend = 1'b0;
        post_touch_report(1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- driver / monitor

  always @(posedge clk_i) begin
    item_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (item_taken) apply_touch_item(touch_items_q.pop_front());
  end

  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !item_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (touch_items_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= touch_items_q[0].func;
        s_axis_tdata  <= touch_items_q[0].word;
        if (tx_burst > 0) begin
          tx_burst--;
        end else begin
          tx_burst = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_on = !rx_on;
        if (rx_on) rx_run = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
        else rx_run = $urandom_range(1, 5);
      end
      rx_run--;
      m_axis_tready <= rx_on;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    result_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (result_taken) begin
      if (touch_reports_q.size() == 0) begin
        report_mismatch("result with none pending", m_axis_tdata[15:0], 16'h0);
      end else begin
        want_r = touch_reports_q.pop_front();
        got_f  = '{16'(m_axis_tuser[0]), 16'(m_axis_tuser[1]), 16'(m_axis_tuser[2]),
                   m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[63:48]};
        want_f = '{16'(want_r.pressed), 16'(want_r.captured), 16'(want_r.read_ok),
                   want_r.x_pos, want_r.y_pos, want_r.first_x, want_r.first_y};
        for (int i = 0; i < 7; i++) begin
          if (got_f[i] !== want_f[i]) report_mismatch(field_name[i], got_f[i], want_f[i]);
        end
      end
    end
  end

  // nothing moving on either side for too long means a hang
  always @(posedge clk_i) begin
    if (item_taken || result_taken) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input cfg_reg_e idx, input logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_RAW_MODE:        cfg_m.raw_mode = val[0];
      CFG_X_SCALE:         cfg_m.x_scale = val;
      CFG_Y_SCALE:         cfg_m.y_scale = val;
      CFG_X_CENTER_RAW:    cfg_m.x_center_raw = val[11:0];
      CFG_Y_CENTER_RAW:    cfg_m.y_center_raw = val[11:0];
      CFG_X_CENTER_SCREEN: cfg_m.x_center_screen = val[15:0];
      CFG_Y_CENTER_SCREEN: cfg_m.y_center_screen = val[15:0];
      CFG_AGREE_WINDOW:    cfg_m.agree_window = val[11:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(input touch_cfg_t c);
    write_reg(CFG_RAW_MODE, 20'(c.raw_mode));
    write_reg(CFG_X_SCALE, c.x_scale);
    write_reg(CFG_Y_SCALE, c.y_scale);
    write_reg(CFG_X_CENTER_RAW, 20'(c.x_center_raw));
    write_reg(CFG_Y_CENTER_RAW, 20'(c.y_center_raw));
    write_reg(CFG_X_CENTER_SCREEN, 20'(c.x_center_screen));
    write_reg(CFG_Y_CENTER_SCREEN, 20'(c.y_center_screen));
    write_reg(CFG_AGREE_WINDOW, 20'(c.agree_window));
  endtask

  function automatic touch_cfg_t random_cfg();
    touch_cfg_t c;
    c.raw_mode        = 1'($urandom);
    c.x_scale         = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(4096, 200000))
                                                    : 20'($urandom);
    c.y_scale         = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(4096, 200000))
                                                    : 20'($urandom);
    c.x_center_raw    = 12'($urandom);
    c.y_center_raw    = 12'($urandom);
    c.x_center_screen = 16'($urandom);
    c.y_center_screen = 16'($urandom);
    c.agree_window    = 12'($urandom_range(1, 400));
    return c;
  endfunction

  function automatic void queue_item(input logic [IN_USER_W-1:0] func,
                                     input logic [IN_DATA_W-1:0] word);
    touch_items_q.push_back(touch_item_t'{func, word});
    if (func != FUNC_UNUSED) counted_items++;
  endfunction

  // samples from..upto of one x,y,x,y scan around the given raw readings
  function automatic void queue_scan(input int xr, input int yr, input int dx, input int dy,
                                     input int noise, input int from, input int upto);
    int base;
    int val;
    int g;
    for (int k = from; k <= upto; k++) begin
      g = k / SAMPLES;
      base = (g % 2 == 0) ? xr + ((g == 2) ? dx : 0) : yr + ((g == 3) ? dy : 0);
      val = base + int'($urandom_range(0, 2 * noise)) - noise;
      // an odd spike now and then, which the trim should drop
      if ($urandom_range(0, 7) == 0) val = $urandom_range(0, 4095);
      if (val < 0) val = 0;
      if (val > 4095) val = 4095;
      queue_item(FUNC_SAMPLE, {12'hfff - 12'(val), 4'($urandom)});
    end
  endfunction

  function automatic int scan_offset(input int spread);
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 8190)) - 4095;
    return int'($urandom_range(0, 3 * spread)) - (3 * spread) / 2;
  endfunction

  function automatic void queue_random_traffic(input int n);
    int stop_at;
    int xr;
    int yr;
    int dx;
    int dy;
    int noise;
    int cut;
    int spread;
    stop_at = counted_items + n;
    spread = (cfg_m.agree_window == 0) ? 20 : int'(cfg_m.agree_window);
    if (spread > 300) spread = 300;
    while (counted_items < stop_at) begin
      xr = $urandom_range(0, 4095);
      yr = $urandom_range(0, 4095);
      dx = scan_offset(spread);
      dy = scan_offset(spread);
      noise = $urandom_range(0, 8);
      cut = $urandom_range(1, SCAN_LEN - 1);
      case ($urandom_range(0, 15))
        10: queue_item(FUNC_PEN_UP, 16'($urandom));
        11: queue_item(FUNC_CLEAR, 16'($urandom));
        12: queue_item(FUNC_UNUSED, 16'($urandom));
        13: begin
          // broken scan, thrown away by pen-up
          queue_scan(xr, yr, dx, dy, noise, 0, cut - 1);
          queue_item(FUNC_PEN_UP, 16'($urandom));
        end
        14: begin
          // clear in the middle of a scan keeps the partial sums
          queue_scan(xr, yr, dx, dy, noise, 0, cut - 1);
          queue_item(FUNC_CLEAR, 16'($urandom));
          queue_scan(xr, yr, dx, dy, noise, cut, SCAN_LEN - 1);
        end
        15: begin
          queue_item(FUNC_SAMPLE, 16'($urandom));
          queue_item(FUNC_PEN_UP, 16'($urandom));
        end
        default: begin
          queue_scan(xr, yr, dx, dy, noise, 0, SCAN_LEN - 1);
          if ($urandom_range(0, 3) == 0) queue_item(FUNC_PEN_UP, 16'($urandom));
        end
      endcase
    end
  endfunction

  function automatic void queue_directed();
    logic [15:0] corner_words [5] = '{16'h0000, 16'hffff, 16'h8000, 16'h7ff0, 16'h800f};
    queue_item(FUNC_PEN_UP, 16'hffff);
    queue_item(FUNC_CLEAR, 16'h0000);
    queue_item(FUNC_UNUSED, 16'ha5a5);
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < SAMPLES; k++) queue_item(FUNC_SAMPLE, corner_words[k]);
    end
    queue_item(FUNC_CLEAR, 16'h5a5a);
    queue_item(FUNC_PEN_UP, 16'h0000);
    queue_item(FUNC_PEN_UP, 16'hffff);
  endfunction

  task automatic wait_drained();
    while (touch_items_q.size() != 0 || touch_reports_q.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    // scan samples leave nothing to wait for, so give the pipeline time to empty
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    touch_cfg_t c;
    reset_filter_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register defaults, then corner items and random traffic
    c = '{1'b0, SCALE_RESET, SCALE_RESET, CENTER_RESET, CENTER_RESET, 16'h0, 16'h0,
          WINDOW_RESET};
    write_all_regs(c);
    queue_directed();
    queue_random_traffic(275);
    wait_drained();

    // raw coordinates with the widest window
    c.raw_mode = 1'b1;
    c.agree_window = 12'hfff;
    write_all_regs(c);
    queue_random_traffic(275);
    wait_drained();

    // zero and full scale, centers at the ends of their ranges
    c = '{1'b0, 20'h0, 20'hfffff, 12'h000, 12'hfff, 16'hffff, 16'h0000, 12'hfff};
    write_all_regs(c);
    queue_random_traffic(275);
    wait_drained();

    // zero window: no scan ever agrees
    c = '{1'b0, 20'hfffff, 20'h0, 12'hfff, 12'h000, 16'h0000, 16'hffff, 12'h000};
    write_all_regs(c);
    queue_random_traffic(250);
    wait_drained();

    // receiver holds off while ticks and clears keep arriving, so the input backs up
    write_all_regs(random_cfg());
    @(posedge clk_i);
    out_hold = LONG_HOLD;
    for (int i = 0; i < 40; i++) queue_item((i % 2 == 0) ? FUNC_PEN_UP : FUNC_CLEAR, 16'($urandom));
    queue_random_traffic(275);
    wait_drained();

    write_all_regs(random_cfg());
    queue_random_traffic(275);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rtsf_pkg.sv
rtl/resistive_touch_sample_filter.sv
rtl/rtsf_port_checker.sv
tb/tb.sv
